@@ rtl/core/cc_cv_charge_controller_defines.svh @@
// Assertion macros for the charge controller RTL.
`ifndef CC_CV_CHARGE_CONTROLLER_DEFINES_SVH
`define CC_CV_CHARGE_CONTROLLER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCCV_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Expression must hold at every clock edge outside reset.
`define CCCV_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error(msg);

`endif

@@ rtl/core/cccv_pkg.sv @@
`default_nettype none

package cccv_pkg;

    // Request codes.
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;

    // Status codes.
    localparam logic [2:0] STATUS_IDLE     = 3'd0;
    localparam logic [2:0] STATUS_CHARGING = 3'd1;
    localparam logic [2:0] STATUS_DONE     = 3'd2;
    localparam logic [2:0] STATUS_OVERTEMP = 3'd3;
    localparam logic [2:0] STATUS_USER     = 3'd4;

    // Register indexes (byte address 4*index).
    localparam logic [1:0] REG_MAX_CURRENT = 2'd0;
    localparam logic [1:0] REG_MAX_VOLTAGE = 2'd1;
    localparam logic [1:0] REG_MAX_TEMP    = 2'd2;

    localparam logic [13:0]        RST_MAX_CURRENT  = 14'd1000;
    localparam logic [15:0]        RST_MAX_VOLTAGE  = 16'd4200;
    localparam logic signed [8:0]  RST_MAX_TEMP     = 9'sd45;
    localparam logic [13:0]        DEFAULT_LIMIT_MA = 14'd3000;

    localparam logic [5:0] LAST_SEC_MIN = 6'd59;

    // Energy is floor(U*I/1000) = floor(floor(U*I/8)/125); the division by 125
    // is a multiply by ceil(2^34/125), exact for all 27-bit dividends.
    localparam int PROD_W      = 30;
    localparam int RECIP_W     = 28;
    localparam int RECIP_SHIFT = 34;
    localparam int QUOT_W      = 21;
    localparam int FULL_W      = PROD_W - 3 + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_125 = 28'd137438954;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [13:0]       current_ma;
        logic [15:0]       voltage_mv;
        logic signed [8:0] temperature_c;
        logic              button_pressed;
    } item_t;

    typedef struct packed {
        logic [13:0]       max_current_ma;
        logic [15:0]       max_voltage_mv;
        logic signed [8:0] max_temperature_c;
    } cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/cccv_energy_pipe.sv @@
`default_nettype none

// Input register, then U*I, then the division by 1000. The request travels
// alongside so that it reaches the state stage together with its quotient.
module cccv_energy_pipe (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire cccv_pkg::item_t             s_item,
    output logic                             c_valid,
    input  wire logic                        c_ready,
    output cccv_pkg::item_t                  c_item,
    output logic [cccv_pkg::QUOT_W-1:0]      c_quot
);

    logic                                a_valid_reg;
    cccv_pkg::item_t                     a_item_reg;
    logic                                b_valid_reg;
    cccv_pkg::item_t                     b_item_reg;
    logic [cccv_pkg::PROD_W-1:0]         b_prod_reg;
    logic [cccv_pkg::PROD_W-1:0]         b_prod_next;
    logic                                c_valid_reg;
    cccv_pkg::item_t                     c_item_reg;
    logic [cccv_pkg::QUOT_W-1:0]         c_quot_reg;
    logic [cccv_pkg::FULL_W-1:0]         c_full;
    logic                                a_ready;
    logic                                b_ready;
    logic                                c_stage_ready;

    assign c_stage_ready = !c_valid_reg || c_ready;
    assign b_ready       = !b_valid_reg || c_stage_ready;
    assign a_ready       = !a_valid_reg || b_ready;
    assign s_ready       = a_ready;

    assign b_prod_next = cccv_pkg::PROD_W'(a_item_reg.voltage_mv)
                       * cccv_pkg::PROD_W'(a_item_reg.current_ma);
    assign c_full = cccv_pkg::FULL_W'(b_prod_reg[cccv_pkg::PROD_W-1:3])
                  * cccv_pkg::FULL_W'(cccv_pkg::RECIP_125);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= s_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_stage_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && s_valid) begin
            a_item_reg <= s_item;
        end
        if (b_ready && a_valid_reg) begin
            b_item_reg <= a_item_reg;
            b_prod_reg <= b_prod_next;
        end
        if (c_stage_ready && b_valid_reg) begin
            c_item_reg <= b_item_reg;
            c_quot_reg <= c_full[cccv_pkg::RECIP_SHIFT +: cccv_pkg::QUOT_W];
        end
    end

    assign c_valid = c_valid_reg;
    assign c_item  = c_item_reg;
    assign c_quot  = c_quot_reg;

endmodule

`default_nettype wire

@@ rtl/core/cccv_core.sv @@
`default_nettype none

// Charge state. The state registers double as the result register: they
// change only when a request moves into the result slot.
module cccv_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire cccv_pkg::cfg_t              cfg,
    input  wire logic                        c_valid,
    output logic                             c_ready,
    input  wire cccv_pkg::item_t             c_item,
    input  wire logic [cccv_pkg::QUOT_W-1:0] c_quot,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [7:0]                       m_pwm_duty,
    output logic                             m_in_cc_mode,
    output logic [2:0]                       m_status,
    output logic [7:0]                       m_elapsed_hours,
    output logic [5:0]                       m_elapsed_minutes,
    output logic [5:0]                       m_elapsed_seconds,
    output logic [31:0]                      m_charge_mas,
    output logic [31:0]                      m_energy_mws
);

    logic        out_valid_reg;
    logic [7:0]  duty_reg,    duty_next;
    logic        cc_mode_reg, cc_mode_next;
    logic [2:0]  status_reg,  status_next;
    logic [5:0]  secs_reg,    secs_next;
    logic [5:0]  mins_reg,    mins_next;
    logic [7:0]  hours_reg,   hours_next;
    logic [31:0] charge_reg,  charge_next;
    logic [31:0] energy_reg,  energy_next;

    logic        commit;
    logic        charging;
    logic [13:0] lim;
    logic [20:0] cur_x100;
    logic [20:0] lim_x95;
    logic [20:0] lim_x105;
    logic [17:0] cur_x10;
    logic [16:0] volt_plus;
    logic        step_up;
    logic        step_down;
    logic        too_hot;

    assign c_ready  = !out_valid_reg || m_ready;
    assign commit   = c_valid && c_ready;
    assign charging = (status_reg == cccv_pkg::STATUS_CHARGING);

    always_comb begin
        lim = (cfg.max_current_ma == 14'd0) ? cccv_pkg::DEFAULT_LIMIT_MA
                                            : cfg.max_current_ma;
        cur_x100  = 21'(c_item.current_ma) * 21'd100;
        lim_x95   = 21'(lim) * 21'd95;
        lim_x105  = 21'(lim) * 21'd105;
        cur_x10   = 18'(c_item.current_ma) * 18'd10;
        volt_plus = 17'(c_item.voltage_mv) + 17'd50;
        too_hot   = c_item.temperature_c > cfg.max_temperature_c;
        if (cc_mode_reg) begin
            step_up   = cur_x100 < lim_x95;
            step_down = cur_x100 > lim_x105;
        end else begin
            step_up   = volt_plus < 17'(cfg.max_voltage_mv);
            step_down = c_item.voltage_mv > cfg.max_voltage_mv;
        end
    end

    always_comb begin
        duty_next    = duty_reg;
        cc_mode_next = cc_mode_reg;
        status_next  = status_reg;
        secs_next    = secs_reg;
        mins_next    = mins_reg;
        hours_next   = hours_reg;
        charge_next  = charge_reg;
        energy_next  = energy_reg;
        unique case (c_item.req_type)
            cccv_pkg::REQ_START: begin
                duty_next    = 8'd0;
                secs_next    = 6'd0;
                mins_next    = 6'd0;
                hours_next   = 8'd0;
                charge_next  = 32'd0;
                energy_next  = 32'd0;
                cc_mode_next = (cfg.max_current_ma != 14'd0);
                status_next  = cccv_pkg::STATUS_CHARGING;
            end
            cccv_pkg::REQ_SAMPLE: begin
                if (charging) begin
                    if (step_up && duty_reg != 8'hFF) begin
                        duty_next = duty_reg + 8'd1;
                    end else if (step_down && duty_reg != 8'd0) begin
                        duty_next = duty_reg - 8'd1;
                    end
                end
            end
            cccv_pkg::REQ_TICK: begin
                if (charging) begin
                    if (secs_reg == cccv_pkg::LAST_SEC_MIN) begin
                        secs_next = 6'd0;
                        if (mins_reg == cccv_pkg::LAST_SEC_MIN) begin
                            mins_next  = 6'd0;
                            hours_next = hours_reg + 8'd1;
                        end else begin
                            mins_next = mins_reg + 6'd1;
                        end
                    end else begin
                        secs_next = secs_reg + 6'd1;
                    end
                    charge_next = charge_reg + 32'(c_item.current_ma);
                    energy_next = energy_reg + 32'(c_quot);
                    if (cc_mode_reg) begin
                        if (c_item.voltage_mv > cfg.max_voltage_mv) begin
                            cc_mode_next = 1'b0;
                        end
                    end else if (cur_x10 < 18'(lim)) begin
                        status_next = cccv_pkg::STATUS_DONE;
                        duty_next   = 8'd0;
                    end else if (c_item.current_ma > lim) begin
                        cc_mode_next = 1'b1;
                    end
                    // Over-temperature wins over the button, which wins over done.
                    if (too_hot) begin
                        status_next = cccv_pkg::STATUS_OVERTEMP;
                        duty_next   = 8'd0;
                    end else if (c_item.button_pressed) begin
                        status_next = cccv_pkg::STATUS_USER;
                        duty_next   = 8'd0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            duty_reg      <= 8'd0;
            cc_mode_reg   <= 1'b0;
            status_reg    <= cccv_pkg::STATUS_IDLE;
            secs_reg      <= 6'd0;
            mins_reg      <= 6'd0;
            hours_reg     <= 8'd0;
            charge_reg    <= 32'd0;
            energy_reg    <= 32'd0;
        end else begin
            if (commit) begin
                out_valid_reg <= 1'b1;
                duty_reg      <= duty_next;
                cc_mode_reg   <= cc_mode_next;
                status_reg    <= status_next;
                secs_reg      <= secs_next;
                mins_reg      <= mins_next;
                hours_reg     <= hours_next;
                charge_reg    <= charge_next;
                energy_reg    <= energy_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_pwm_duty        = duty_reg;
    assign m_in_cc_mode      = cc_mode_reg;
    assign m_status          = status_reg;
    assign m_elapsed_hours   = hours_reg;
    assign m_elapsed_minutes = mins_reg;
    assign m_elapsed_seconds = secs_reg;
    assign m_charge_mas      = charge_reg;
    assign m_energy_mws      = energy_reg;

endmodule

`default_nettype wire

@@ rtl/core/cc_cv_charge_controller.sv @@
// Channel   Direction  Handshake           Payload
// s_*       in         s_valid / s_ready   req_type, current, voltage, temperature, button
// m_*       out        m_valid / m_ready   duty, mode, status, elapsed time, charge, energy
// apb       in         psel/penable/pready max current, max voltage, max temperature
//
// One request per cycle while m_ready does not stall the output, one result per request.
// From acceptance to m_valid a request passes the input register, the U*I product
// register, the reciprocal multiply register and then the state update register.
// aresetn is synchronous and active low; it clears the charge state and reloads the limits.
// With m_ready low, four requests are held inside (three behind the waiting result)
// before s_ready drops.
`default_nettype none

`include "cc_cv_charge_controller_defines.svh"

module cc_cv_charge_controller (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_req_type,
    input  wire logic [13:0]       s_current_ma,
    input  wire logic [15:0]       s_voltage_mv,
    input  wire logic signed [8:0] s_temperature_c,
    input  wire logic              s_button_pressed,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [7:0]             m_pwm_duty,
    output logic                   m_in_cc_mode,
    output logic [2:0]             m_status,
    output logic [7:0]             m_elapsed_hours,
    output logic [5:0]             m_elapsed_minutes,
    output logic [5:0]             m_elapsed_seconds,
    output logic [31:0]            m_charge_mas,
    output logic [31:0]            m_energy_mws,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    cccv_pkg::cfg_t                 cfg_reg;
    cccv_pkg::item_t                s_item;
    cccv_pkg::item_t                c_item;
    logic [cccv_pkg::QUOT_W-1:0]    c_quot;
    logic                           c_valid;
    logic                           c_ready;
    logic                           cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_current_ma    <= cccv_pkg::RST_MAX_CURRENT;
            cfg_reg.max_voltage_mv    <= cccv_pkg::RST_MAX_VOLTAGE;
            cfg_reg.max_temperature_c <= cccv_pkg::RST_MAX_TEMP;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                cccv_pkg::REG_MAX_CURRENT: cfg_reg.max_current_ma <= pwdata[13:0];
                cccv_pkg::REG_MAX_VOLTAGE: cfg_reg.max_voltage_mv <= pwdata[15:0];
                cccv_pkg::REG_MAX_TEMP:    cfg_reg.max_temperature_c <= pwdata[8:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            cccv_pkg::REG_MAX_CURRENT: prdata = 32'(cfg_reg.max_current_ma);
            cccv_pkg::REG_MAX_VOLTAGE: prdata = 32'(cfg_reg.max_voltage_mv);
            cccv_pkg::REG_MAX_TEMP:    prdata = 32'(cfg_reg.max_temperature_c);
            default:                   prdata = 32'd0;
        endcase
    end

    assign s_item.req_type       = s_req_type;
    assign s_item.current_ma     = s_current_ma;
    assign s_item.voltage_mv     = s_voltage_mv;
    assign s_item.temperature_c  = s_temperature_c;
    assign s_item.button_pressed = s_button_pressed;

    cccv_energy_pipe u_energy (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .c_valid (c_valid),
        .c_ready (c_ready),
        .c_item  (c_item),
        .c_quot  (c_quot)
    );

    cccv_core u_core (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .c_valid           (c_valid),
        .c_ready           (c_ready),
        .c_item            (c_item),
        .c_quot            (c_quot),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pwm_duty        (m_pwm_duty),
        .m_in_cc_mode      (m_in_cc_mode),
        .m_status          (m_status),
        .m_elapsed_hours   (m_elapsed_hours),
        .m_elapsed_minutes (m_elapsed_minutes),
        .m_elapsed_seconds (m_elapsed_seconds),
        .m_charge_mas      (m_charge_mas),
        .m_energy_mws      (m_energy_mws)
    );

    // The input side can only back up when every stage is full and the result waits.
    `CCCV_ASSERT_IMPL(a_ready_only_when_full, aclk, aresetn, !s_ready, m_valid && !m_ready, "s_ready low without a stalled result")
    // Any state other than charging leaves the supply off.
    `CCCV_ASSERT_IMPL(a_stopped_duty_zero, aclk, aresetn, m_status != cccv_pkg::STATUS_CHARGING, m_pwm_duty == 8'd0, "duty nonzero while not charging")
    // Before the first start nothing has been timed or accumulated.
    `CCCV_ASSERT_IMPL(a_idle_clear, aclk, aresetn, m_status == cccv_pkg::STATUS_IDLE, m_elapsed_seconds == 6'd0 && m_charge_mas == 32'd0 && m_energy_mws == 32'd0, "idle with nonzero totals")
    // Seconds and minutes stay between 0 and 59.
    `CCCV_ASSERT_ALWAYS(a_time_range, aclk, aresetn, m_elapsed_seconds <= 6'd59 && m_elapsed_minutes <= 6'd59, "elapsed time out of range")

endmodule

`default_nettype wire

@@ tb/cc_cv_charge_controller_test.sv @@
`timescale 1ns / 100ps

module cc_cv_charge_controller_test;
    import cccv_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 100_000;
    localparam int QUIET_CYCLES = 8;

    typedef struct packed {
        logic [7:0]  pwm_duty;
        logic        in_cc_mode;
        logic [2:0]  status;
        logic [7:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [31:0] charge_mas;
        logic [31:0] energy_mws;
    } charge_report_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_req_type = REQ_SAMPLE;
    logic [13:0]       s_current_ma = '0;
    logic [15:0]       s_voltage_mv = '0;
    logic signed [8:0] s_temperature_c = '0;
    logic              s_button_pressed = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [7:0]        m_pwm_duty;
    logic              m_in_cc_mode;
    logic [2:0]        m_status;
    logic [7:0]        m_elapsed_hours;
    logic [5:0]        m_elapsed_minutes;
    logic [5:0]        m_elapsed_seconds;
    logic [31:0]       m_charge_mas;
    logic [31:0]       m_energy_mws;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [3:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    cc_cv_charge_controller uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_current_ma      (s_current_ma),
        .s_voltage_mv      (s_voltage_mv),
        .s_temperature_c   (s_temperature_c),
        .s_button_pressed  (s_button_pressed),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pwm_duty        (m_pwm_duty),
        .m_in_cc_mode      (m_in_cc_mode),
        .m_status          (m_status),
        .m_elapsed_hours   (m_elapsed_hours),
        .m_elapsed_minutes (m_elapsed_minutes),
        .m_elapsed_seconds (m_elapsed_seconds),
        .m_charge_mas      (m_charge_mas),
        .m_energy_mws      (m_energy_mws),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #5 aclk = ~aclk;

    // Charger state as the testbench expects it, and the limits last written.
    cfg_t        limits;
    logic [7:0]  pred_duty = '0;
    logic        pred_cc = 1'b0;
    logic [2:0]  pred_status = STATUS_IDLE;
    logic [5:0]  pred_secs = '0;
    logic [5:0]  pred_mins = '0;
    logic [7:0]  pred_hours = '0;
    logic [31:0] pred_charge = '0;
    logic [31:0] pred_energy = '0;

    item_t          request_queue[$];
    charge_report_t pending_reports[$];
    item_t          held_request;
    charge_report_t predicted;
    charge_report_t oldest_report;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             failures = 0;
    int             cycles = 0;
    int             phase_items = 0;

    task automatic halt_charge(input logic [2:0] code);
        pred_status = code;
        pred_duty = '0;
    endtask

    task automatic advance_charger(input item_t rq, output charge_report_t rp);
        int unsigned lim;
        int unsigned vlim;
        int unsigned cur;
        int unsigned volt;
        logic up;
        logic down;
        lim = (limits.max_current_ma == 0) ? DEFAULT_LIMIT_MA : limits.max_current_ma;
        vlim = limits.max_voltage_mv;
        cur = rq.current_ma;
        volt = rq.voltage_mv;
        case (rq.req_type)
            REQ_START: begin
                pred_duty = '0;
                pred_secs = '0;
                pred_mins = '0;
                pred_hours = '0;
                pred_charge = '0;
                pred_energy = '0;
                pred_cc = (limits.max_current_ma != 0);
                pred_status = STATUS_CHARGING;
            end
            REQ_SAMPLE: begin
                if (pred_status == STATUS_CHARGING) begin
                    if (pred_cc) begin
                        up = (100 * cur < 95 * lim);
                        down = (100 * cur > 105 * lim);
                    end else begin
                        up = (volt + 50 < vlim);
                        down = (volt > vlim);
                    end
                    if (up && pred_duty != 8'hFF) begin
                        pred_duty = pred_duty + 8'd1;
                    end else if (down && pred_duty != 8'h00) begin
                        pred_duty = pred_duty - 8'd1;
                    end
                end
            end
            REQ_TICK: begin
                if (pred_status == STATUS_CHARGING) begin
                    if (pred_secs == LAST_SEC_MIN) begin
                        pred_secs = '0;
                        if (pred_mins == LAST_SEC_MIN) begin
                            pred_mins = '0;
                            pred_hours = pred_hours + 8'd1;
                        end else begin
                            pred_mins = pred_mins + 6'd1;
                        end
                    end else begin
                        pred_secs = pred_secs + 6'd1;
                    end
                    pred_charge = pred_charge + cur;
                    pred_energy = pred_energy + (volt * cur) / 1000;
                    if (pred_cc) begin
                        if (volt > vlim) pred_cc = 1'b0;
                    end else if (10 * cur < lim) begin
                        halt_charge(STATUS_DONE);
                    end else if (cur > lim) begin
                        pred_cc = 1'b1;
                    end
                    // The stop button outranks done, and overheating outranks both.
                    if (rq.button_pressed) halt_charge(STATUS_USER);
                    if ($signed(rq.temperature_c) > $signed(limits.max_temperature_c)) begin
                        halt_charge(STATUS_OVERTEMP);
                    end
                end
            end
            default: ;
        endcase
        rp.pwm_duty = pred_duty;
        rp.in_cc_mode = pred_cc;
        rp.status = pred_status;
        rp.hours = pred_hours;
        rp.minutes = pred_mins;
        rp.seconds = pred_secs;
        rp.charge_mas = pred_charge;
        rp.energy_mws = pred_energy;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_charger(held_request, predicted);
                pending_reports.push_back(predicted);
            end
            if (!s_valid || s_ready) begin
                if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    held_request = request_queue.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= held_request.req_type;
                    s_current_ma <= held_request.current_ma;
                    s_voltage_mv <= held_request.voltage_mv;
                    s_temperature_c <= held_request.temperature_c;
                    s_button_pressed <= held_request.button_pressed;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            failures++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                failures++;
                $error("result arrived with no request pending");
            end else begin
                oldest_report = pending_reports.pop_front();
                check_field("pwm_duty", oldest_report.pwm_duty, m_pwm_duty);
                check_field("in_cc_mode", oldest_report.in_cc_mode, m_in_cc_mode);
                check_field("status", oldest_report.status, m_status);
                check_field("elapsed_hours", oldest_report.hours, m_elapsed_hours);
                check_field("elapsed_minutes", oldest_report.minutes, m_elapsed_minutes);
                check_field("elapsed_seconds", oldest_report.seconds, m_elapsed_seconds);
                check_field("charge_mas", oldest_report.charge_mas, m_charge_mas);
                check_field("energy_mws", oldest_report.energy_mws, m_energy_mws);
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("cc_cv_charge_controller_test: done, errors");
            $finish;
        end
    end

    function automatic int clip(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic item_t make_request(input logic [1:0] kind, input int cur,
                                           input int volt, input int temp, input logic btn);
        item_t rq;
        rq.req_type = kind;
        rq.current_ma = cur[13:0];
        rq.voltage_mv = volt[15:0];
        rq.temperature_c = temp[8:0];
        rq.button_pressed = btn;
        return rq;
    endfunction

    // Values cluster around the regulation thresholds of the limits now in force.
    function automatic item_t make_random_request(input logic [1:0] kind);
        int lim;
        int vlim;
        int tlim;
        int jitter;
        int c;
        int v;
        int t;
        lim = (limits.max_current_ma == 0) ? int'(DEFAULT_LIMIT_MA) : int'(limits.max_current_ma);
        vlim = int'(limits.max_voltage_mv);
        tlim = int'($signed(limits.max_temperature_c));
        jitter = int'($urandom_range(4)) - 2;
        case ($urandom_range(5))
            0: c = int'($urandom_range(16383));
            1: c = lim * 95 / 100 + jitter;
            2: c = lim * 105 / 100 + jitter;
            3: c = lim / 10 + jitter;
            4: c = lim + jitter;
            default: c = int'($urandom_range(50));
        endcase
        case ($urandom_range(3))
            0: v = int'($urandom_range(65535));
            1: v = vlim + jitter;
            2: v = vlim - 50 + jitter;
            default: v = int'($urandom_range(vlim));
        endcase
        if ($urandom_range(9) == 0 || tlim < -40) begin
            t = int'($urandom_range(190)) - 40;
        end else begin
            t = int'($urandom_range(tlim + 40)) - 40;
        end
        return make_request(kind, clip(c, 0, 16383), clip(v, 0, 65535), t,
                            $urandom_range(39) == 0);
    endfunction

    task automatic queue_charge_cycle(input int len);
        int roll;
        request_queue.push_back(make_random_request(REQ_START));
        phase_items++;
        repeat (len) begin
            roll = $urandom_range(99);
            if (roll < 62) begin
                request_queue.push_back(make_random_request(REQ_SAMPLE));
            end else if (roll < 94) begin
                request_queue.push_back(make_random_request(REQ_TICK));
            end else if (roll < 97) begin
                request_queue.push_back(make_random_request(REQ_UNUSED));
            end else begin
                request_queue.push_back(make_random_request(REQ_START));
            end
            phase_items++;
        end
    endtask

    task automatic wait_drained();
        int quiet;
        quiet = 0;
        while (quiet < QUIET_CYCLES) begin
            @(posedge aclk);
            if (request_queue.size() == 0 && !s_valid && pending_reports.size() == 0) begin
                quiet++;
            end else begin
                quiet = 0;
            end
        end
    endtask

    task automatic reg_write(input logic [1:0] index, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_MAX_CURRENT: limits.max_current_ma = value[13:0];
            REG_MAX_VOLTAGE: limits.max_voltage_mv = value[15:0];
            REG_MAX_TEMP:    limits.max_temperature_c = value[8:0];
            default: ;
        endcase
    endtask

    task automatic apply_limits(input int cur, input int volt, input int temp);
        reg_write(REG_MAX_CURRENT, 32'(cur));
        reg_write(REG_MAX_VOLTAGE, 32'(volt));
        reg_write(REG_MAX_TEMP, 32'(temp) & 32'h1FF);
    endtask

    initial begin
        int phase;
        limits.max_current_ma = RST_MAX_CURRENT;
        limits.max_voltage_mv = RST_MAX_VOLTAGE;
        limits.max_temperature_c = RST_MAX_TEMP;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 13;
        recv_idle_pct = 76;
        // Directed part, run against the limits loaded by reset.
        request_queue.push_back(make_request(REQ_SAMPLE, 0, 0, 0, 1'b0));
        request_queue.push_back(make_request(REQ_TICK, 16383, 65535, 150, 1'b1));
        request_queue.push_back(make_request(REQ_UNUSED, 16383, 65535, -40, 1'b1));
        request_queue.push_back(make_request(REQ_START, 16383, 65535, 150, 1'b1));
        request_queue.push_back(make_request(REQ_SAMPLE, 0, 0, -40, 1'b0));
        request_queue.push_back(make_request(REQ_SAMPLE, 16383, 65535, 150, 1'b1));
        request_queue.push_back(make_request(REQ_SAMPLE, 16383, 0, 0, 1'b0));
        request_queue.push_back(make_request(REQ_SAMPLE, 950, 0, 0, 1'b0));
        request_queue.push_back(make_request(REQ_SAMPLE, 949, 0, 0, 1'b0));
        request_queue.push_back(make_request(REQ_SAMPLE, 1050, 0, 0, 1'b0));
        request_queue.push_back(make_request(REQ_SAMPLE, 1051, 0, 0, 1'b0));
        request_queue.push_back(make_request(REQ_TICK, 1000, 4200, 45, 1'b0));
        request_queue.push_back(make_request(REQ_TICK, 1000, 4201, 45, 1'b0));
        request_queue.push_back(make_request(REQ_SAMPLE, 0, 4149, 0, 1'b0));
        request_queue.push_back(make_request(REQ_SAMPLE, 0, 4150, 0, 1'b0));
        request_queue.push_back(make_request(REQ_SAMPLE, 16383, 4201, 0, 1'b0));
        request_queue.push_back(make_request(REQ_TICK, 1001, 4200, 0, 1'b0));
        request_queue.push_back(make_request(REQ_TICK, 500, 65535, 0, 1'b0));
        request_queue.push_back(make_request(REQ_TICK, 99, 0, 0, 1'b0));
        request_queue.push_back(make_request(REQ_SAMPLE, 0, 0, 0, 1'b0));
        request_queue.push_back(make_request(REQ_START, 0, 0, 0, 1'b0));
        request_queue.push_back(make_request(REQ_TICK, 16383, 65535, 46, 1'b1));
        request_queue.push_back(make_request(REQ_START, 0, 0, 0, 1'b0));
        request_queue.push_back(make_request(REQ_TICK, 100, 4201, 0, 1'b0));
        request_queue.push_back(make_request(REQ_TICK, 0, 0, -40, 1'b1));
        request_queue.push_back(make_request(REQ_START, 0, 0, 0, 1'b0));
        request_queue.push_back(make_request(REQ_TICK, 50, 100, 0, 1'b0));
        request_queue.push_back(make_request(REQ_START, 0, 0, 0, 1'b0));
        request_queue.push_back(make_request(REQ_TICK, 16383, 65535, -1, 1'b0));

        for (phase = 0; phase < 6; phase++) begin
            wait_drained();
            case (phase)
                0: apply_limits(0, 4200, 45);
                1: apply_limits(16383, 65535, 150);
                2: apply_limits(1, 0, -40);
                3: apply_limits(2000, 3700, 60);
                4: apply_limits(500, 8400, 0);
                default: apply_limits(3000, 100, -1);
            endcase
            send_idle_pct = (phase < 2) ? 13 : ((phase < 4) ? 76 : 0);
            recv_idle_pct = (phase < 2) ? 76 : ((phase < 4) ? 13 : 0);
            phase_items = 0;
            if (phase == 0) begin
                // No current limit, so charging runs in CV: drive the duty
                // into both rails.
                request_queue.push_back(make_random_request(REQ_START));
                repeat (260) begin
                    request_queue.push_back(make_request(REQ_SAMPLE,
                        int'($urandom_range(16383)), int'($urandom_range(4149)), 0, 1'b0));
                end
                repeat (260) begin
                    request_queue.push_back(make_request(REQ_SAMPLE,
                        int'($urandom_range(16383)), int'($urandom_range(65535, 4201)), 0, 1'b0));
                end
            end
            while (phase_items < 55) queue_charge_cycle($urandom_range(60, 8));
            // Let everything outstanding come back before sending more.
            wait_drained();
            while (phase_items < 110) queue_charge_cycle($urandom_range(60, 8));
        end

        wait_drained();
        if (failures == 0) begin
            $display("cc_cv_charge_controller_test: done, clean");
        end else begin
            $display("cc_cv_charge_controller_test: done, errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/cccv_pkg.sv
rtl/core/cccv_energy_pipe.sv
rtl/core/cccv_core.sv
rtl/core/cc_cv_charge_controller.sv
tb/cc_cv_charge_controller_test.sv
